FILE: rtl/umpl_pkg.sv
// Shared widths, register codes, constants and the log10 helper of the urban micro path loss block.
package umpl_pkg;

  localparam int LOG_TABLE_BITS_DEF = 8;
  localparam int DIST_FRAC_BITS_DEF = 4;

  localparam int DIST_W     = 20;
  localparam int CARRIER_W  = 17;
  localparam int HEIGHT_W   = 10;
  localparam int BP_W       = 16;
  localparam int LOSS_W     = 18;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 17;

  // signed Q16 log width and signed Q32 accumulator width
  localparam int LG_W  = 24;
  localparam int ACC_W = 56;

  localparam logic [CARRIER_W-1:0] CARRIER_RST = 17'd5900;
  localparam logic [HEIGHT_W-1:0]  BASE_H_RST  = 10'd250;
  localparam logic [HEIGHT_W-1:0]  TERM_H_RST  = 10'd15;
  localparam logic [BP_W-1:0]      BP_RST      = 16'd944;
  localparam logic                 MODE_RST    = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CARRIER  = 3'd0,
    REG_BASE_H   = 3'd1,
    REG_TERM_H   = 3'd2,
    REG_BP       = 3'd3,
    REG_LINK_MODE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic los;
    logic near;
    logic zero;
  } side_t;

  localparam logic signed [LG_W-1:0] ONE_Q16   = 24'sd65536;
  localparam logic signed [LG_W-1:0] THREE_Q16 = 24'sd196608;

  localparam logic signed [ACC_W-1:0] C_227  = 56'sd1487667;
  localparam logic signed [ACC_W-1:0] C_20   = 56'sd1310720;
  localparam logic signed [ACC_W-1:0] C_40   = 56'sd2621440;
  localparam logic signed [ACC_W-1:0] C_449  = 56'sd2942566;
  localparam logic signed [ACC_W-1:0] C_655  = 56'sd429261;
  localparam logic signed [ACC_W-1:0] C_3497 = 56'sd2291794;
  localparam logic signed [ACC_W-1:0] C_583  = 56'sd382075;

  // additive terms already in Q32
  localparam logic signed [ACC_W-1:0] C_41_Q32   = 56'sd2686976 <<< 16;
  localparam logic signed [ACC_W-1:0] C_FAR_Q32  = 56'sd839063 <<< 16;
  localparam logic signed [ACC_W-1:0] C_NLOS_Q32 = 56'sd640942 <<< 16;
  localparam logic signed [ACC_W-1:0] C_FS_Q32   = 56'sd2124716 <<< 16;

  localparam logic signed [ACC_W-1:0] HALF_Q24 = 56'sd8388608;
  localparam logic signed [ACC_W-25:0] LOSS_MIN = -32'sd65536;
  localparam logic signed [ACC_W-25:0] LOSS_MAX = 32'sd131071;

  localparam logic signed [ACC_W-1:0] K_LOG10_2 = 56'sd1292913986;

  // log10 in Q16 from log2 in Q16, rounded toward minus infinity
  function automatic logic signed [LG_W-1:0] log10_q16(input logic signed [LG_W-1:0] lg2);
    logic signed [ACC_W-1:0] p;
    p = ACC_W'(lg2) * K_LOG10_2;
    return p[LG_W+31:32];
  endfunction

endpackage

FILE: rtl/umpl_log2.sv
// Pipelined log2 in Q16: leading-one normalize, then one mantissa squaring per stage.
module umpl_log2 #(
  parameter int W = 20,
  parameter int L = 8
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [W-1:0]                 x,
  output logic [$clog2(W)+16-1:0]      lg2
);

  localparam int E = $clog2(W);

  logic [E-1:0]  e_r [0:L];
  logic [30:0]   m_r [0:L];
  logic [L-1:0]  f_r [0:L];

  logic [E-1:0]    e_nxt;
  logic [W+29:0]   ext;
  logic [30:0]     m_nxt;

  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < W; i++) begin
      if (x[i]) begin
        e_nxt = E'(i);
      end
    end
    ext   = {x, 30'b0} >> e_nxt;
    m_nxt = ext[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= e_nxt;
      m_r[0] <= m_nxt;
      f_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= L; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = 62'(m_r[k-1]) * 62'(m_r[k-1]);
    assign t  = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        e_r[k] <= e_r[k-1];
        // renormalize when the square reaches two
        m_r[k] <= t[31] ? t[31:1] : t[30:0];
        f_r[k] <= {f_r[k-1][L-2:0], t[31]};
      end
    end
  end

  assign lg2 = {e_r[L], f_r[L], {(16-L){1'b0}}};

endmodule

FILE: rtl/umpl_eval.sv
// Loss evaluation stages: log10 scaling, coefficient products, sums, model select and floor.
module umpl_eval #(
  parameter int D_W            = 21,
  parameter int C_W            = 21,
  parameter int H_W            = 20,
  parameter int DIST_FRAC_BITS = umpl_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [D_W-1:0]                      lg2_d,
  input  logic [C_W-1:0]                      lg2_c,
  input  logic [H_W-1:0]                      lg2_h,
  input  logic [H_W-1:0]                      lg2_t,
  input  umpl_pkg::side_t                     side_i,
  output logic signed [umpl_pkg::ACC_W-1:0]   best,
  output logic                                fs_used,
  output umpl_pkg::side_t                     side_o
);

  localparam int LGW = umpl_pkg::LG_W;
  localparam int AW  = umpl_pkg::ACC_W;

  // log10 stage
  logic signed [LGW-1:0] lgd_in;
  logic signed [LGW-1:0] ld_r, lf_r, lh_r, lt_r;
  umpl_pkg::side_t       side_l_r;

  assign lgd_in = LGW'(lg2_d) - (LGW'(DIST_FRAC_BITS) << 16);

  always_ff @(posedge clk) begin
    if (en) begin
      ld_r     <= umpl_pkg::log10_q16(lgd_in);
      lf_r     <= umpl_pkg::log10_q16(LGW'(lg2_c)) - umpl_pkg::THREE_Q16;
      lh_r     <= umpl_pkg::log10_q16(LGW'(lg2_h)) - umpl_pkg::ONE_Q16;
      lt_r     <= umpl_pkg::log10_q16(LGW'(lg2_t)) - umpl_pkg::ONE_Q16;
      side_l_r <= side_i;
    end
  end

  // product stage
  logic signed [AW-1:0]  p655_r, p227_r, p40_r, p20d_r, p20f_r, p3497_r, p583_r;
  logic signed [LGW-1:0] ld_a_r;
  umpl_pkg::side_t       side_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p655_r   <= AW'(lh_r) * umpl_pkg::C_655;
      p227_r   <= AW'(ld_r) * umpl_pkg::C_227;
      p40_r    <= AW'(ld_r) * umpl_pkg::C_40;
      p20d_r   <= AW'(ld_r) * umpl_pkg::C_20;
      p20f_r   <= AW'(lf_r) * umpl_pkg::C_20;
      p3497_r  <= AW'(lf_r) * umpl_pkg::C_3497;
      p583_r   <= AW'(lt_r) * umpl_pkg::C_583;
      ld_a_r   <= ld_r;
      side_a_r <= side_l_r;
    end
  end

  // slope product and partial sums
  logic signed [AW-1:0] slope_full;
  logic signed [31:0]   slope;
  logic signed [AW-1:0] prod_n_r, near_r, far_r, fs_r, nlr_r;
  umpl_pkg::side_t      side_b_r;

  assign slope_full = umpl_pkg::C_449 - (p655_r >>> 16);
  assign slope      = slope_full[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_n_r <= AW'(slope) * AW'(ld_a_r);
      near_r   <= p227_r + umpl_pkg::C_41_Q32 + p20f_r;
      far_r    <= p40_r + umpl_pkg::C_FAR_Q32;
      fs_r     <= p20d_r + umpl_pkg::C_FS_Q32 + p20f_r;
      nlr_r    <= umpl_pkg::C_NLOS_Q32 + p3497_r + p583_r;
      side_b_r <= side_a_r;
    end
  end

  // model select and free-space floor; a tie keeps the model value
  logic signed [AW-1:0] nlos, model;
  logic                 fs_gt;
  logic signed [AW-1:0] best_r;
  logic                 fsu_r;
  umpl_pkg::side_t      side_c_r;

  always_comb begin
    nlos = prod_n_r + nlr_r;
    if (side_b_r.los) begin
      model = side_b_r.near ? near_r : far_r;
    end else begin
      model = nlos;
    end
    fs_gt = fs_r > model;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      best_r   <= fs_gt ? fs_r : model;
      fsu_r    <= fs_gt;
      side_c_r <= side_b_r;
    end
  end

  assign best    = best_r;
  assign fs_used = fsu_r;
  assign side_o  = side_c_r;

endmodule

FILE: rtl/urban_micro_path_loss.sv
// Urban micro path loss: LoS/NLoS loss in dB with a free-space floor, one item per cycle.
// Throughput: one item per cycle; the log2 squaring chain sets the pipeline depth.
// The whole pipeline advances together; it holds while the output register waits.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
module urban_micro_path_loss #(
  parameter int LOG_TABLE_BITS = umpl_pkg::LOG_TABLE_BITS_DEF,
  parameter int DIST_FRAC_BITS = umpl_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,   // [19:0] distance_q4, [23:20] zero
  input  logic                             in_tuser,   // [0] line-of-sight flag
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // [17:0] loss_db_q8, [23:18] zero
  output logic [1:0]                       out_tuser,  // [0] free_space_used, [1] zero_distance
  input  logic                             cfg_we,
  input  logic [umpl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [umpl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int LAT   = LOG_TABLE_BITS + 1;
  localparam int DEPTH = LAT + 4;
  localparam int CMP_W = umpl_pkg::BP_W + DIST_FRAC_BITS + 1;
  localparam int DE    = $clog2(umpl_pkg::DIST_W) + 16;
  localparam int CE    = $clog2(umpl_pkg::CARRIER_W) + 16;
  localparam int HE    = $clog2(umpl_pkg::HEIGHT_W) + 16;
  localparam int AW    = umpl_pkg::ACC_W;

  // configuration registers
  logic [umpl_pkg::CARRIER_W-1:0] carrier_r;
  logic [umpl_pkg::HEIGHT_W-1:0]  base_h_r, term_h_r;
  logic [umpl_pkg::BP_W-1:0]      bp_r;
  logic                           mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r <= umpl_pkg::CARRIER_RST;
      base_h_r  <= umpl_pkg::BASE_H_RST;
      term_h_r  <= umpl_pkg::TERM_H_RST;
      bp_r      <= umpl_pkg::BP_RST;
      mode_r    <= umpl_pkg::MODE_RST;
    end else if (cfg_we) begin
      case (umpl_pkg::cfg_reg_t'(cfg_addr))
        umpl_pkg::REG_CARRIER:   carrier_r <= cfg_wdata;
        umpl_pkg::REG_BASE_H:    base_h_r  <= cfg_wdata[umpl_pkg::HEIGHT_W-1:0];
        umpl_pkg::REG_TERM_H:    term_h_r  <= cfg_wdata[umpl_pkg::HEIGHT_W-1:0];
        umpl_pkg::REG_BP:        bp_r      <= cfg_wdata[umpl_pkg::BP_W-1:0];
        umpl_pkg::REG_LINK_MODE: mode_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic out_tvalid_r;
  logic en;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // input decode
  logic [umpl_pkg::DIST_W-1:0]    dist_in;
  logic [umpl_pkg::CARRIER_W-1:0] carrier_eff;
  logic [umpl_pkg::HEIGHT_W-1:0]  hsel, hsel_eff, term_eff;
  umpl_pkg::side_t                side_in;

  assign dist_in     = in_tdata[umpl_pkg::DIST_W-1:0];
  assign carrier_eff = (carrier_r == '0) ? umpl_pkg::CARRIER_W'(1) : carrier_r;
  assign hsel        = mode_r ? base_h_r : term_h_r;
  assign hsel_eff    = (hsel == '0) ? umpl_pkg::HEIGHT_W'(1) : hsel;
  assign term_eff    = (term_h_r == '0) ? umpl_pkg::HEIGHT_W'(1) : term_h_r;

  assign side_in.los  = in_tuser;
  assign side_in.zero = (dist_in == '0);
  assign side_in.near = (CMP_W'(dist_in) > (CMP_W'(10) << DIST_FRAC_BITS)) &&
                        (CMP_W'(dist_in) < (CMP_W'(bp_r) << DIST_FRAC_BITS));

  // log2 lanes
  logic [DE-1:0] lg2_d;
  logic [CE-1:0] lg2_c;
  logic [HE-1:0] lg2_h, lg2_t;

  umpl_log2 #(.W(umpl_pkg::DIST_W), .L(LOG_TABLE_BITS)) u_log_d (
    .clk(clk), .en(en), .x(dist_in), .lg2(lg2_d)
  );
  umpl_log2 #(.W(umpl_pkg::CARRIER_W), .L(LOG_TABLE_BITS)) u_log_c (
    .clk(clk), .en(en), .x(carrier_eff), .lg2(lg2_c)
  );
  umpl_log2 #(.W(umpl_pkg::HEIGHT_W), .L(LOG_TABLE_BITS)) u_log_h (
    .clk(clk), .en(en), .x(hsel_eff), .lg2(lg2_h)
  );
  umpl_log2 #(.W(umpl_pkg::HEIGHT_W), .L(LOG_TABLE_BITS)) u_log_t (
    .clk(clk), .en(en), .x(term_eff), .lg2(lg2_t)
  );

  // side data alongside the log2 lanes
  umpl_pkg::side_t side_r [0:LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  logic [DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  logic signed [AW-1:0] best;
  logic                 fs_used;
  umpl_pkg::side_t      side_o;

  umpl_eval #(.D_W(DE), .C_W(CE), .H_W(HE), .DIST_FRAC_BITS(DIST_FRAC_BITS)) u_eval (
    .clk(clk), .en(en),
    .lg2_d(lg2_d), .lg2_c(lg2_c), .lg2_h(lg2_h), .lg2_t(lg2_t),
    .side_i(side_r[LAT-1]),
    .best(best), .fs_used(fs_used), .side_o(side_o)
  );

  // round half up to Q8 and saturate
  logic signed [AW-1:0]  rnd;
  logic signed [AW-25:0] q8;
  logic [umpl_pkg::LOSS_W-1:0] loss_nxt;

  always_comb begin
    rnd = best + umpl_pkg::HALF_Q24;
    q8  = rnd[AW-1:24];
    if (side_o.zero || q8 < umpl_pkg::LOSS_MIN) begin
      loss_nxt = umpl_pkg::LOSS_MIN[umpl_pkg::LOSS_W-1:0];
    end else if (q8 > umpl_pkg::LOSS_MAX) begin
      loss_nxt = umpl_pkg::LOSS_MAX[umpl_pkg::LOSS_W-1:0];
    end else begin
      loss_nxt = q8[umpl_pkg::LOSS_W-1:0];
    end
  end

  logic [umpl_pkg::LOSS_W-1:0] loss_r;
  logic [1:0]                  flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vld_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      loss_r  <= loss_nxt;
      flags_r <= {side_o.zero, fs_used && !side_o.zero};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(24-umpl_pkg::LOSS_W){1'b0}}, loss_r};
  assign out_tuser  = flags_r;

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && out_tdata[17:0] == 18'h30000)
    else $error("zero-distance item without saturated result");

  a_floor_above_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[17:0] != 18'h30000)
    else $error("nonzero distance reached the loss minimum");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(loss_r))
    else $error("pipeline moved while the output was stalled");

endmodule
